### rtl/core/display_list_sequencer_macros.svh
// assertion macros for the display list sequencer
// no dependencies; included by the top level only
`ifndef DISPLAY_LIST_SEQUENCER_MACROS_SVH
`define DISPLAY_LIST_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication under reset
`define DLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("display list sequencer check failed");
// next-cycle implication under reset
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("display list sequencer check failed");
`else
`define DLS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/dls_pkg.sv
// types, codes and helper functions for the display list sequencer
// no dependencies
package dls_pkg;

    localparam logic [2:0] OP_BEGIN_LINE  = 3'd0;
    localparam logic [2:0] OP_FINISH_LINE = 3'd1;
    localparam logic [2:0] OP_CYCLE_TICK  = 3'd2;
    localparam logic [2:0] OP_INSTR_BYTE  = 3'd3;
    localparam logic [2:0] OP_OPERAND     = 3'd4;
    localparam logic [2:0] OP_PTR_WRITE   = 3'd5;

    localparam logic [8:0] FIRST_LINE  = 9'd8;
    localparam logic [8:0] LAST_LINE   = 9'd247;
    localparam logic [8:0] VBLANK_LINE = 9'd248;

    localparam logic [6:0] CYC_LATCH_START = 7'd0;
    localparam logic [6:0] CYC_INSTR_FETCH = 7'd1;
    localparam logic [6:0] CYC_DLI_CHECK   = 7'd5;
    localparam logic [6:0] CYC_OPERAND_LO  = 7'd6;
    localparam logic [6:0] CYC_OPERAND_HI  = 7'd7;
    localparam logic [6:0] CYC_LATCH_END   = 7'd108;

    localparam logic [3:0] MODE_BLANK = 4'd0;
    localparam logic [3:0] MODE_JUMP  = 4'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  scanline;
        logic [6:0]  machine_cycle;
        logic [3:0]  vscroll;
        logic        playfield_dma_on;
        logic        fetch_enabled;
        logic        missile_slot_on;
        logic        byte_index;
        logic [15:0] data;
    } dls_in_t;

    typedef struct packed {
        logic        dma_request;
        logic        dma_kind;
        logic        dma_byte;
        logic [15:0] fetch_address;
        logic        dli_fire;
        logic        clear_ring;
        logic        line_reset;
        logic        missile_snoop;
        logic [15:0] scan_address;
        logic [3:0]  current_row;
        logic        first_line;
    } dls_out_t;

    typedef struct packed {
        logic [7:0]  instr;
        logic [15:0] scan;
        logic [3:0]  row_count;
        logic [3:0]  last_row;
        logic        valid_flag;
        logic        need_fetch;
        logic        wait_vblank;
        logic        load_scan;
        logic        vs_active;
        logic        vs_ending;
        logic        first_line;
        logic [1:0]  operands_left;
        logic [15:0] line_addr;
        logic [3:0]  vs_start;
        logic [3:0]  vs_dli;
        logic [3:0]  vs_end;
        logic [15:0] list_pointer;
    } dls_state_t;

    localparam dls_state_t STATE_RESET = '{
        instr: 8'd0, scan: 16'd0, row_count: 4'd0, last_row: 4'd0,
        valid_flag: 1'b0, need_fetch: 1'b1, wait_vblank: 1'b0,
        load_scan: 1'b0, vs_active: 1'b0, vs_ending: 1'b0,
        first_line: 1'b0, operands_left: 2'd0, line_addr: 16'd0,
        vs_start: 4'd0, vs_dli: 4'd0, vs_end: 4'd0, list_pointer: 16'd0
    };

    // last row index of each mode line (height minus one)
    function automatic logic [3:0] mode_last_row(input logic [3:0] mode);
        logic [3:0] r;
        case (mode)
            4'd2:    r = 4'd7;
            4'd3:    r = 4'd9;
            4'd4:    r = 4'd7;
            4'd5:    r = 4'd15;
            4'd6:    r = 4'd7;
            4'd7:    r = 4'd15;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd3;
            4'd10:   r = 4'd3;
            4'd11:   r = 4'd1;
            4'd13:   r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // pointer advances within its 1 KB page
    function automatic logic [15:0] next_pointer(input logic [15:0] a);
        logic [9:0] low;
        low = a[9:0] + 10'd1;
        return {a[15:10], low};
    endfunction

    // decode of a freshly loaded instruction
    function automatic dls_state_t start_instr(input dls_state_t s);
        dls_state_t n;
        logic [3:0] mode;
        n = s;
        mode = s.instr[3:0];
        n.operands_left = 2'd0;
        n.line_addr = 16'd0;
        n.first_line = 1'b1;
        n.vs_active = (mode >= 4'd2) && s.instr[5];
        n.vs_ending = s.vs_active && !n.vs_active;
        n.row_count = (n.vs_active && !s.vs_active) ? s.vs_start : 4'd0;
        if (mode == MODE_BLANK)
        begin
            n.last_row = {1'b0, s.instr[6:4]};
        end
        else if (mode == MODE_JUMP)
        begin
            n.last_row = 4'd0;
            n.operands_left = 2'd2;
        end
        else
        begin
            n.last_row = mode_last_row(mode);
            n.load_scan = s.instr[6];
            n.operands_left = s.instr[6] ? 2'd2 : 2'd0;
            n.line_addr = s.scan;
        end
        return n;
    endfunction

endpackage

### rtl/core/dls_ifs.sv
// valid/ready channel interfaces for events and results
// depends on dls_pkg
interface dls_event_if import dls_pkg::*; ();
    logic    valid;
    logic    ready;
    dls_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dls_result_if import dls_pkg::*; ();
    logic     valid;
    logic     ready;
    dls_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/dls_step.sv
// next state and result for one event
// depends on dls_pkg
module dls_step import dls_pkg::*; (
    input  dls_state_t cur,
    input  dls_in_t    item,
    output dls_state_t nxt,
    output dls_out_t   result
);

    always_comb
    begin
        dls_state_t s;
        logic in_range;
        logic done;
        logic [3:0] mode;
        logic [3:0] last;
        logic req, kind, dbyte, dli, clr, lres, snoop;

        s = cur;
        in_range = (item.scanline >= FIRST_LINE) && (item.scanline <= LAST_LINE);
        done = 1'b0;
        mode = cur.instr[3:0];
        last = 4'd0;
        req = 1'b0; kind = 1'b0; dbyte = 1'b0;
        dli = 1'b0; clr = 1'b0; lres = 1'b0; snoop = 1'b0;

        case (item.opcode)
            OP_BEGIN_LINE:
            begin
                if (item.scanline == VBLANK_LINE)
                begin
                    s.instr[6] = 1'b0;
                    clr = 1'b1;
                end
                if (item.scanline == FIRST_LINE && s.wait_vblank)
                begin
                    s.wait_vblank = 1'b0;
                    s.need_fetch = 1'b1;
                end
                lres = 1'b1;
            end
            OP_FINISH_LINE:
            begin
                if (in_range && s.valid_flag)
                begin
                    if (s.wait_vblank)
                    begin
                        if (s.vs_ending && s.row_count != s.last_row)
                        begin
                            s.row_count = s.row_count + 4'd1;
                            s.first_line = 1'b0;
                        end
                        else
                        begin
                            s.row_count = 4'd0;
                            s.last_row = 4'd0;
                            s.vs_ending = 1'b0;
                            s.first_line = 1'b1;
                        end
                    end
                    else if (s.row_count == s.last_row)
                    begin
                        s.need_fetch = 1'b1;
                        s.row_count = 4'd0;
                    end
                    else
                    begin
                        s.row_count = s.row_count + 4'd1;
                        s.first_line = 1'b0;
                    end
                end
            end
            OP_CYCLE_TICK:
            begin
                if (item.machine_cycle == CYC_LATCH_START)
                begin
                    s.vs_start = item.vscroll;
                    // reload jump operands when a scroll region ends on a jump
                    if (!s.need_fetch && !s.wait_vblank && s.vs_ending
                        && mode == MODE_JUMP && !s.instr[6] && s.row_count != 4'd0)
                    begin
                        s.operands_left = 2'd2;
                        s.line_addr = 16'd0;
                    end
                end
                if (item.machine_cycle == CYC_DLI_CHECK)
                begin
                    s.vs_dli = item.vscroll;
                    if (in_range && s.valid_flag && !s.need_fetch && s.instr[7])
                    begin
                        last = s.vs_ending ? s.vs_dli : s.last_row;
                        if (s.row_count == last)
                            dli = 1'b1;
                    end
                end
                if (item.machine_cycle == CYC_LATCH_END)
                begin
                    s.vs_end = item.vscroll;
                    if (s.vs_ending)
                        s.last_row = item.vscroll;
                end
                if (in_range && !s.wait_vblank)
                begin
                    if (item.machine_cycle == CYC_INSTR_FETCH && s.need_fetch)
                    begin
                        if (item.fetch_enabled)
                        begin
                            req = 1'b1;
                            done = 1'b1;
                        end
                        else if (s.valid_flag)
                        begin
                            s.need_fetch = 1'b0;
                            clr = (s.instr[3:0] < 4'd2);
                            s = start_instr(s);
                        end
                    end
                    if (!done && item.playfield_dma_on && s.operands_left != 2'd0
                        && (item.machine_cycle == CYC_OPERAND_LO
                            || item.machine_cycle == CYC_OPERAND_HI))
                    begin
                        req = 1'b1;
                        kind = 1'b1;
                        dbyte = (item.machine_cycle == CYC_OPERAND_HI);
                    end
                end
            end
            OP_INSTR_BYTE:
            begin
                s.instr = item.data[7:0];
                snoop = !item.missile_slot_on;
                s.list_pointer = next_pointer(s.list_pointer);
                s.valid_flag = 1'b1;
                s.need_fetch = 1'b0;
                clr = (item.data[3:0] < 4'd2);
                s = start_instr(s);
            end
            OP_OPERAND:
            begin
                s.list_pointer = next_pointer(s.list_pointer);
                if (item.byte_index)
                    s.line_addr = {item.data[7:0], s.line_addr[7:0]};
                else
                    s.line_addr = {s.line_addr[15:8], item.data[7:0]};
                s.operands_left = s.operands_left - 2'd1;
                if (s.operands_left == 2'd0)
                begin
                    if (mode == MODE_JUMP)
                    begin
                        s.list_pointer = s.line_addr;
                        if (s.instr[6])
                            s.wait_vblank = 1'b1;
                    end
                    else
                    begin
                        s.scan = s.line_addr;
                    end
                end
            end
            OP_PTR_WRITE:
            begin
                s.list_pointer = item.data;
            end
            default:
            begin
                s = cur;
            end
        endcase

        nxt = s;
        result.dma_request   = req;
        result.dma_kind      = kind;
        result.dma_byte      = dbyte;
        result.fetch_address = s.list_pointer;
        result.dli_fire      = dli;
        result.clear_ring    = clr;
        result.line_reset    = lres;
        result.missile_snoop = snoop;
        result.scan_address  = s.scan;
        result.current_row   = s.row_count;
        result.first_line    = s.first_line;
    end

endmodule

### rtl/core/display_list_sequencer.sv
// display list sequencer top level: input register, step logic, result register
// depends on dls_pkg, dls_ifs, dls_step and display_list_sequencer_macros.svh
//
//  channel  | dir | handshake     | payload
//  evt      | in  | valid / ready | dls_in_t: opcode, scan position, scroll, enables, data
//  res      | out | valid / ready | dls_out_t: dma request, strobes, addresses, row
//
// one event per clock sustained while res.ready holds; an event passes through the input register
// and then the result register before res.valid rises
// the state register updates as an event leaves the input register for the result register
// rst_n clears the sequencer state and both valid flags
// a stalled result holds the input register, which in turn drops evt.ready
`include "display_list_sequencer_macros.svh"

module display_list_sequencer import dls_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    dls_event_if.sink          evt,
    dls_result_if.source       res
);

    logic       s1_valid_reg;
    dls_in_t    s1_item_reg;
    logic       out_valid_reg;
    dls_out_t   out_item_reg;
    dls_state_t state_reg;
    dls_state_t state_next;
    dls_out_t   result_next;
    logic       s1_adv;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || s1_adv;

    dls_step u_step (
        .cur    (state_reg),
        .item   (s1_item_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (evt.ready)
                s1_valid_reg <= evt.valid;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            s1_item_reg <= evt.payload;
        if (s1_adv)
            out_item_reg <= result_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_item_reg;

    // an accepted event finds room in the input register
    `DLS_ASSERT_NOW(a_room_on_transfer, clk, rst_n, evt.valid && evt.ready, !s1_valid_reg || s1_adv)
    // a blocked input register keeps its event and the sequencer state
    `DLS_ASSERT_NEXT(a_hold_when_blocked, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_item_reg) && $stable(state_reg))
    // an instruction byte leaves the list valid and the fetch satisfied
    `DLS_ASSERT_NEXT(a_instr_loads, clk, rst_n, s1_adv && s1_item_reg.opcode == OP_INSTR_BYTE, state_reg.valid_flag && !state_reg.need_fetch && state_reg.first_line)

endmodule
